[sv/assert_macros.svh]
// Assertion macros shared by the framer RTL; compiled out under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property checked on every rising clk edge outside reset.
`define MDSF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("framer assertion failed");
// Expression that must never hold outside reset.
`define MDSF_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("framer forbidden condition");
`else
`define MDSF_ASSERT(lbl, prop)
`define MDSF_NEVER(lbl, expr)
`endif
`endif

[sv/mdsf_pkg.sv]
// Types and constants of the multidrop serial slave framer.
package mdsf_pkg;

  // Event codes
  localparam logic [2:0] CMD_RX_BYTE   = 3'd0;
  localparam logic [2:0] CMD_LINE_IDLE = 3'd1;
  localparam logic [2:0] CMD_TX_READY  = 3'd2;
  localparam logic [2:0] CMD_TX_DONE   = 3'd3;
  localparam logic [2:0] CMD_RESP_WR   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_SELF_ADDR = 2'd0;
  localparam logic [1:0] REG_CMD_MASK  = 2'd1;
  localparam logic [1:0] REG_RX_LEN    = 2'd2;
  localparam logic [1:0] REG_TX_LEN    = 2'd3;

  localparam int CFG_DW = 60;
  // Command codes stay below this bound regardless of table size
  localparam logic [7:0] CODE_LIMIT = 8'd15;
  // Header bytes (address and code) counted ahead of the data bytes
  localparam logic [4:0] HDR_BYTES = 5'd2;
  localparam logic [4:0] COUNT_MAX = 5'd31;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] data_byte;
    logic       parity_error;
    logic [3:0] resp_code;
    logic [3:0] resp_index;
  } in_item_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       tx_request;
    logic       mute;
    logic       rx_valid;
    logic [3:0] rx_position;
    logic [7:0] rx_data;
    logic       frame_done;
    logic [3:0] frame_command;
    logic       tx_error;
    logic       tx_done;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  self_address;
    logic [14:0] command_enable_mask;
    logic [59:0] rx_length_table;
    logic [59:0] tx_length_table;
  } cfg_t;

  // Response store access requested by one event
  typedef struct packed {
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;
    logic       re;
    logic [7:0] raddr;
  } store_req_t;

  // Per-command length field; code 15 has no entry
  function automatic logic [3:0] nibble(logic [59:0] tbl, logic [3:0] code);
    logic [3:0] val;
    val = 4'd0;
    if (code != 4'd15) begin
      val = tbl[{code, 2'b00} +: 4];
    end
    return val;
  endfunction

endpackage

[sv/mdsf_ctrl.sv]
// Receive and reply sequencing of the framer: state registers and per-event decisions.
`include "assert_macros.svh"
module mdsf_ctrl
  import mdsf_pkg::*;
#(
  parameter int NUM_COMMANDS = 15,
  parameter int MAX_RESPONSE = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       fire,
  input  in_item_t   item,
  input  cfg_t       cfg,
  output out_item_t  res,
  output store_req_t req
);

  localparam logic [1:0] PH_ADDR = 2'd0;
  localparam logic [1:0] PH_CODE = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;
  localparam logic [1:0] PH_WAIT = 2'd3;

  localparam logic [1:0] TX_IDLE = 2'd0;
  localparam logic [1:0] TX_CONF = 2'd1;
  localparam logic [1:0] TX_DATA = 2'd2;
  localparam logic [1:0] TX_LAST = 2'd3;

  localparam logic [4:0] RESP_MAX = 5'(MAX_RESPONSE);

  logic [1:0] rx_phase_r, rx_phase_nxt;
  logic [4:0] rx_count_r, rx_count_nxt;
  logic [3:0] cur_cmd_r, cur_cmd_nxt;
  logic [1:0] tx_phase_r, tx_phase_nxt;
  logic [4:0] tx_rem_r, tx_rem_nxt;
  logic [3:0] tx_off_r, tx_off_nxt;

  logic [4:0]  count_inc;
  logic [15:0] mask_ext;
  logic        code_ok;
  logic [3:0]  rx_len_code;
  logic [3:0]  rx_len_cur;
  logic [4:0]  tx_len_code;

  assign count_inc   = (rx_count_r < COUNT_MAX) ? rx_count_r + 5'd1 : rx_count_r;
  assign mask_ext    = {1'b0, cfg.command_enable_mask};
  assign code_ok     = !item.parity_error && (item.data_byte < 8'(NUM_COMMANDS)) &&
                       (item.data_byte < CODE_LIMIT) && mask_ext[item.data_byte[3:0]];
  assign rx_len_code = nibble(cfg.rx_length_table, item.data_byte[3:0]);
  assign rx_len_cur  = nibble(cfg.rx_length_table, cur_cmd_r);

  always_comb begin
    logic [4:0] n;
    n = {1'b0, nibble(cfg.tx_length_table, item.data_byte[3:0])};
    tx_len_code = (n > RESP_MAX) ? RESP_MAX : n;
  end

  always_comb begin
    rx_phase_nxt = rx_phase_r;
    rx_count_nxt = rx_count_r;
    cur_cmd_nxt  = cur_cmd_r;
    tx_phase_nxt = tx_phase_r;
    tx_rem_nxt   = tx_rem_r;
    tx_off_nxt   = tx_off_r;
    res          = '0;
    req          = '0;
    req.waddr    = {4'd0, item.resp_code} * 8'(MAX_RESPONSE) + {4'd0, item.resp_index};
    req.wdata    = item.data_byte;
    req.raddr    = {4'd0, cur_cmd_r} * 8'(MAX_RESPONSE) + {4'd0, tx_off_r};

    case (item.cmd)
      CMD_RX_BYTE: begin
        rx_count_nxt = count_inc;
        case (rx_phase_r)
          PH_ADDR: begin
            if (item.parity_error || item.data_byte != cfg.self_address) begin
              res.mute     = 1'b1;
              rx_count_nxt = 5'd0;
            end else begin
              rx_phase_nxt = PH_CODE;
            end
          end
          PH_CODE: begin
            if (!code_ok) begin
              res.mute     = 1'b1;
              rx_phase_nxt = PH_ADDR;
              rx_count_nxt = 5'd0;
            end else begin
              cur_cmd_nxt = item.data_byte[3:0];
              if (rx_len_code == 4'd0) begin
                rx_phase_nxt   = PH_WAIT;
                rx_count_nxt   = 5'd0;
                tx_phase_nxt   = TX_CONF;
                tx_rem_nxt     = tx_len_code;
                tx_off_nxt     = 4'd0;
                res.frame_done = 1'b1;
              end else begin
                rx_phase_nxt = PH_DATA;
              end
            end
          end
          PH_DATA: begin
            if (item.parity_error) begin
              res.mute     = 1'b1;
              rx_phase_nxt = PH_ADDR;
              rx_count_nxt = 5'd0;
            end else begin
              res.rx_valid    = 1'b1;
              res.rx_position = 4'(count_inc - 5'd3);
              res.rx_data     = item.data_byte;
              // A lowered length ends the frame at the first byte that reaches it
              if (count_inc >= {1'b0, rx_len_cur} + HDR_BYTES) begin
                rx_phase_nxt   = PH_WAIT;
                rx_count_nxt   = 5'd0;
                tx_phase_nxt   = TX_CONF;
                tx_rem_nxt     = 5'd0;
                tx_off_nxt     = 4'd0;
                res.frame_done = 1'b1;
              end
            end
          end
          default: begin
            // reply in progress: drop the byte
            res.mute     = 1'b1;
            rx_count_nxt = 5'd0;
          end
        endcase
      end
      CMD_LINE_IDLE: begin
        rx_count_nxt = 5'd0;
        if (rx_phase_r != PH_WAIT) begin
          rx_phase_nxt = PH_ADDR;
        end
      end
      CMD_TX_READY: begin
        if (tx_phase_r == TX_CONF) begin
          res.tx_valid = 1'b1;
          res.tx_byte  = cfg.self_address;
          tx_phase_nxt = (tx_rem_r != 5'd0) ? TX_DATA : TX_LAST;
        end else if (tx_phase_r == TX_DATA) begin
          if (tx_rem_r != 5'd0) begin
            res.tx_valid = 1'b1;
            req.re       = 1'b1;
            tx_off_nxt   = tx_off_r + 4'd1;
            tx_rem_nxt   = tx_rem_r - 5'd1;
          end
          if (tx_rem_nxt == 5'd0) begin
            tx_phase_nxt = TX_LAST;
          end
        end
      end
      CMD_TX_DONE: begin
        if (tx_phase_r == TX_LAST || (tx_phase_r == TX_CONF && tx_rem_r == 5'd0)) begin
          res.tx_done  = 1'b1;
          tx_phase_nxt = TX_IDLE;
          rx_phase_nxt = PH_ADDR;
          rx_count_nxt = 5'd0;
        end else if (tx_phase_r != TX_IDLE) begin
          // early completion: abort the reply
          res.tx_error = 1'b1;
          tx_phase_nxt = TX_IDLE;
          tx_rem_nxt   = 5'd0;
          rx_phase_nxt = PH_ADDR;
          rx_count_nxt = 5'd0;
        end
      end
      CMD_RESP_WR: begin
        req.we = ({4'd0, item.resp_code} < 8'(NUM_COMMANDS)) &&
                 ({4'd0, item.resp_index} < 8'(MAX_RESPONSE));
      end
      default: begin
      end
    endcase

    res.tx_request    = (tx_phase_nxt == TX_CONF) || (tx_phase_nxt == TX_DATA);
    res.frame_command = cur_cmd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rx_phase_r <= PH_ADDR;
      rx_count_r <= 5'd0;
      cur_cmd_r  <= 4'd0;
      tx_phase_r <= TX_IDLE;
      tx_rem_r   <= 5'd0;
      tx_off_r   <= 4'd0;
    end else if (fire) begin
      rx_phase_r <= rx_phase_nxt;
      rx_count_r <= rx_count_nxt;
      cur_cmd_r  <= cur_cmd_nxt;
      tx_phase_r <= tx_phase_nxt;
      tx_rem_r   <= tx_rem_nxt;
      tx_off_r   <= tx_off_nxt;
    end
  end

  // receiver waits exactly while a reply is under way
  `MDSF_ASSERT(a_wait_matches_reply, (rx_phase_r == PH_WAIT) == (tx_phase_r != TX_IDLE))
  `MDSF_NEVER(a_rem_bound, tx_rem_r > RESP_MAX)
  `MDSF_ASSERT(a_done_starts_reply, fire && res.frame_done |=> tx_phase_r == TX_CONF)

endmodule

[sv/multidrop_uart_slave_framer.sv]
// Top level of the multidrop serial slave framer: channels, configuration, response store.
// One event enters per cycle while the result side does not stall. A transfer lands in the
// input register, and its result moves into the result register once that is empty or being
// taken, to be presented from there. A stalled result holds only the input register behind it.
// Response bytes come from a store of NUM_COMMANDS * MAX_RESPONSE bytes (240 by default) whose
// registered read is issued with the result and is registered alongside it. The store is not
// cleared after reset: a response byte must be written before the reply that sends it.
`include "assert_macros.svh"
module multidrop_uart_slave_framer
  import mdsf_pkg::*;
#(
  parameter int NUM_COMMANDS = 15,
  parameter int MAX_RESPONSE = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_item_t          in_item,
  output logic              out_valid,
  input  logic              out_stall,
  output out_item_t         out_item,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [CFG_DW-1:0] cfg_wdata
);

  localparam int DEPTH = NUM_COMMANDS * MAX_RESPONSE;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t       cfg_r;
  in_item_t   in_q_r;
  logic       in_q_valid_r;
  out_item_t  out_r;
  logic       out_valid_r;
  logic       use_mem_r;
  logic [7:0] rd_data_r;
  logic [7:0] mem [DEPTH];

  logic       fire;
  out_item_t  res;
  store_req_t req;

  assign fire      = in_q_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_q_valid_r && !fire;
  assign out_valid = out_valid_r;

  always_comb begin
    out_item = out_r;
    if (use_mem_r) begin
      out_item.tx_byte = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SELF_ADDR: cfg_r.self_address        <= cfg_wdata[7:0];
        REG_CMD_MASK:  cfg_r.command_enable_mask <= cfg_wdata[14:0];
        REG_RX_LEN:    cfg_r.rx_length_table     <= cfg_wdata[59:0];
        REG_TX_LEN:    cfg_r.tx_length_table     <= cfg_wdata[59:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_q_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      in_q_valid_r <= (in_valid && !in_stall) || (in_q_valid_r && !fire);
      out_valid_r  <= fire || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q_r <= in_item;
    end
    if (fire) begin
      out_r     <= res;
      use_mem_r <= req.re;
    end
  end

  // response store: one write and one registered read port
  always_ff @(posedge clk) begin
    if (fire && req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    if (fire && req.re) begin
      rd_data_r <= mem[req.raddr[AW-1:0]];
    end
  end

  mdsf_ctrl #(
    .NUM_COMMANDS(NUM_COMMANDS),
    .MAX_RESPONSE(MAX_RESPONSE)
  ) u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .fire (fire),
    .item (in_q_r),
    .cfg  (cfg_r),
    .res  (res),
    .req  (req)
  );

  // a held item is never lost while the result side stalls
  `MDSF_ASSERT(a_hold_item, in_q_valid_r && !fire |=> in_q_valid_r)
  `MDSF_ASSERT(a_fire_fills_out, fire |=> out_valid_r)
  `MDSF_NEVER(a_read_and_write, fire && req.re && req.we)

endmodule

[tb/sv/multidrop_uart_slave_framer_tb.sv]
// Self-checking testbench for the multidrop serial slave framer: directed table, then random frames.
`timescale 1ns / 100ps
module multidrop_uart_slave_framer_tb;
  import mdsf_pkg::*;

  localparam logic [2:0] CMD_SPARE_5 = 3'd5;
  localparam logic [2:0] CMD_SPARE_7 = 3'd7;
  localparam int NUM_PHASES = 6;
  localparam int PHASE_EVENTS = 140;

  typedef enum logic [1:0] {RX_ADDR, RX_CODE, RX_DATA, RX_WAIT} rx_phase_t;
  typedef enum logic [1:0] {TX_IDLE, TX_CONF, TX_DATA, TX_LAST} tx_phase_t;
  typedef enum logic {ROW_EVENT, ROW_SETUP} row_kind_t;

  // A typed row carries its result as mute / tx_error / tx_done / frame_command, rest zero.
  typedef struct packed {
    row_kind_t  kind;
    logic [2:0] cmd;
    logic [7:0] data;
    logic       perr;
    logic [3:0] code;
    logic [3:0] idx;
    logic       typed;
    logic       mute;
    logic       err;
    logic       done;
    logic [3:0] fc;
  } dir_row_t;

  localparam cfg_t DIR_CFG = '{8'hFF, 15'h7FFF, 60'hFFF_FFFF_FFFF_FFF0, 60'hFFF_FFFF_FFFF_FFF1};

  localparam int DIR_N = 28;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{ROW_EVENT, CMD_RX_BYTE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_TX_DONE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_SPARE_7,   8'hFF, 1'b1, 4'hF, 4'hF, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_SETUP, CMD_RX_BYTE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RESP_WR,   8'hAA, 1'b1, 4'hF, 4'hF, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RESP_WR,   8'hFF, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_LINE_IDLE, 8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'hFF, 1'b1, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'hFE, 1'b0, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'hFF, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'h0F, 1'b0, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'hFF, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'h55, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_TX_READY,  8'h00, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_TX_READY,  8'h00, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_TX_READY,  8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_TX_DONE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b1, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'hFF, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'h0E, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'hFF, 1'b1, 4'h0, 4'h0, 1'b1, 1'b1, 1'b0, 1'b0, 4'hE},
    '{ROW_EVENT, CMD_TX_DONE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0, 4'hE},
    '{ROW_EVENT, CMD_SPARE_5,   8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b0, 1'b0, 4'hE},
    '{ROW_EVENT, CMD_RX_BYTE,   8'hFF, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_RX_BYTE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b0, 1'b0, 1'b0, 1'b0, 4'h0},
    '{ROW_EVENT, CMD_TX_DONE,   8'h00, 1'b0, 4'h0, 4'h0, 1'b1, 1'b0, 1'b1, 1'b0, 4'h0}
  };

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_item_t          in_item;
  logic              out_valid;
  logic              out_stall;
  out_item_t         out_item;
  logic              cfg_we;
  logic [1:0]        cfg_index;
  logic [CFG_DW-1:0] cfg_wdata;

  // Predicted configuration and framer state
  logic [7:0]  cfg_self;
  logic [14:0] cfg_mask;
  logic [59:0] cfg_rx_len;
  logic [59:0] cfg_tx_len;
  rx_phase_t   rx_ph;
  logic [4:0]  rx_cnt;
  logic [3:0]  cur_code;
  tx_phase_t   tx_ph;
  logic [4:0]  tx_left;
  logic [3:0]  tx_ofs;
  logic [7:0]  resp_mem [256];
  bit          resp_written [256];

  out_item_t due_results [$];
  int        mismatch_count = 0;
  int        sent = 0;
  int        gap_odds = 4;
  bit        quiet = 1'b0;

  multidrop_uart_slave_framer u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("multidrop_uart_slave_framer: mismatch");
    $finish;
  end

  function automatic bit one_in(int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  // Code 15 shifts the whole 60-bit table out and reads as zero.
  function automatic logic [3:0] len_of(logic [59:0] tbl, logic [3:0] code);
    return 4'(tbl >> {code, 2'b00});
  endfunction

  function automatic void open_reply(logic [3:0] n);
    rx_ph   = RX_WAIT;
    rx_cnt  = '0;
    tx_ph   = TX_CONF;
    tx_left = {1'b0, n};
    tx_ofs  = '0;
  endfunction

  function automatic out_item_t framer_step(in_item_t it);
    out_item_t r;
    logic [3:0] len;
    r = '0;
    case (it.cmd)
      CMD_RX_BYTE: begin
        if (rx_cnt != COUNT_MAX) rx_cnt++;
        case (rx_ph)
          RX_ADDR: begin
            if (it.parity_error || it.data_byte != cfg_self) begin
              r.mute = 1'b1;
              rx_cnt = '0;
            end else begin
              rx_ph = RX_CODE;
            end
          end
          RX_CODE: begin
            if (it.parity_error || it.data_byte >= CODE_LIMIT ||
                !cfg_mask[it.data_byte[3:0]]) begin
              r.mute = 1'b1;
              rx_ph  = RX_ADDR;
              rx_cnt = '0;
            end else begin
              cur_code = it.data_byte[3:0];
              if (len_of(cfg_rx_len, cur_code) == 4'd0) begin
                open_reply(len_of(cfg_tx_len, cur_code));
                r.frame_done = 1'b1;
              end else begin
                rx_ph = RX_DATA;
              end
            end
          end
          RX_DATA: begin
            if (it.parity_error) begin
              r.mute = 1'b1;
              rx_ph  = RX_ADDR;
              rx_cnt = '0;
            end else begin
              len           = len_of(cfg_rx_len, cur_code);
              r.rx_valid    = 1'b1;
              r.rx_position = rx_cnt[3:0] - 4'd3;
              r.rx_data     = it.data_byte;
              if (rx_cnt >= 5'(len) + HDR_BYTES) begin
                open_reply(4'd0);
                r.frame_done = 1'b1;
              end
            end
          end
          default: begin
            // bytes during a reply are muted and dropped
            r.mute = 1'b1;
            rx_cnt = '0;
          end
        endcase
      end
      CMD_LINE_IDLE: begin
        rx_cnt = '0;
        if (rx_ph != RX_WAIT) rx_ph = RX_ADDR;
      end
      CMD_TX_READY: begin
        if (tx_ph == TX_CONF) begin
          r.tx_valid = 1'b1;
          r.tx_byte  = cfg_self;
          tx_ph      = (tx_left != 0) ? TX_DATA : TX_LAST;
        end else if (tx_ph == TX_DATA) begin
          if (tx_left != 0) begin
            r.tx_valid = 1'b1;
            r.tx_byte  = resp_mem[{cur_code, tx_ofs}];
            tx_ofs++;
            tx_left--;
          end
          if (tx_left == 0) tx_ph = TX_LAST;
        end
      end
      CMD_TX_DONE: begin
        if (tx_ph == TX_LAST || (tx_ph == TX_CONF && tx_left == 0)) begin
          r.tx_done = 1'b1;
          tx_ph     = TX_IDLE;
          rx_ph     = RX_ADDR;
          rx_cnt    = '0;
        end else if (tx_ph != TX_IDLE) begin
          r.tx_error = 1'b1;
          tx_ph      = TX_IDLE;
          tx_left    = '0;
          rx_ph      = RX_ADDR;
          rx_cnt     = '0;
        end
      end
      CMD_RESP_WR: begin
        if (it.resp_code != CODE_LIMIT[3:0]) begin
          resp_mem[{it.resp_code, it.resp_index}]     = it.data_byte;
          resp_written[{it.resp_code, it.resp_index}] = 1'b1;
        end
      end
      default: ;
    endcase
    r.tx_request    = (tx_ph == TX_CONF || tx_ph == TX_DATA);
    r.frame_command = cur_code;
    return r;
  endfunction

  function automatic string field_diffs(out_item_t w, out_item_t g);
    string s;
    s = "";
    if (w.tx_valid      !== g.tx_valid)      s = {s, " tx_valid"};
    if (w.tx_byte       !== g.tx_byte)       s = {s, " tx_byte"};
    if (w.tx_request    !== g.tx_request)    s = {s, " tx_request"};
    if (w.mute          !== g.mute)          s = {s, " mute"};
    if (w.rx_valid      !== g.rx_valid)      s = {s, " rx_valid"};
    if (w.rx_position   !== g.rx_position)   s = {s, " rx_position"};
    if (w.rx_data       !== g.rx_data)       s = {s, " rx_data"};
    if (w.frame_done    !== g.frame_done)    s = {s, " frame_done"};
    if (w.frame_command !== g.frame_command) s = {s, " frame_command"};
    if (w.tx_error      !== g.tx_error)      s = {s, " tx_error"};
    if (w.tx_done       !== g.tx_done)       s = {s, " tx_done"};
    return s;
  endfunction

  function automatic void log_failure(string what, out_item_t w, out_item_t g);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("%0t: %s: expected %h actual %h", $time, what, w, g);
  endfunction

  function automatic in_item_t mk_item(logic [2:0] cmd, logic [7:0] b, logic perr);
    in_item_t it;
    it.cmd          = cmd;
    it.data_byte    = b;
    it.parity_error = perr;
    it.resp_code    = 4'($urandom);
    it.resp_index   = 4'($urandom);
    return it;
  endfunction

  function automatic logic [59:0] random_lengths();
    logic [59:0] tbl;
    int r;
    tbl = '0;
    for (int c = 0; c < 15; c++) begin
      r = $urandom_range(0, 9);
      if (r >= 9) tbl[c*4 +: 4] = 4'($urandom_range(5, 15));
      else if (r >= 4) tbl[c*4 +: 4] = 4'($urandom_range(1, 4));
    end
    return tbl;
  endfunction

  // Called at a falling edge; returns at the next falling edge after the transfer, or after a random idle gap.
  task automatic drive_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t pred;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    pred = framer_step(it);
    due_results.push_back(typed ? typed_res : pred);
    sent++;
    @(negedge clk);
    if (!quiet && gap_odds != 0 && one_in(gap_odds)) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
  endtask

  task automatic send_event(in_item_t it);
    in_item_t fill;
    // fill the slot the next response byte is read from, so no unwritten entry is read
    if (it.cmd == CMD_TX_READY && tx_ph == TX_DATA && tx_left != 0 &&
        !resp_written[{cur_code, tx_ofs}]) begin
      fill            = mk_item(CMD_RESP_WR, 8'($urandom), 1'($urandom));
      fill.resp_code  = cur_code;
      fill.resp_index = tx_ofs;
      drive_item(fill, 1'b0, '0);
    end
    drive_item(it, 1'b0, '0);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_DW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  task automatic load_config(cfg_t c);
    write_reg(REG_SELF_ADDR, CFG_DW'(c.self_address));
    write_reg(REG_CMD_MASK, CFG_DW'(c.command_enable_mask));
    write_reg(REG_RX_LEN, c.rx_length_table);
    write_reg(REG_TX_LEN, c.tx_length_table);
    cfg_we     <= 1'b0;
    cfg_self   = c.self_address;
    cfg_mask   = c.command_enable_mask;
    cfg_rx_len = c.rx_length_table;
    cfg_tx_len = c.tx_length_table;
  endtask

  task automatic send_frame();
    logic [7:0] b;
    logic [3:0] code;
    int guard;
    int r;
    case ($urandom_range(0, 2))
      0: gap_odds = 0;
      1: gap_odds = 3;
      default: gap_odds = 10;
    endcase
    if (one_in(8)) send_event(mk_item(CMD_LINE_IDLE, 8'($urandom), 1'($urandom)));
    b = one_in(7) ? 8'($urandom) : cfg_self;
    send_event(mk_item(CMD_RX_BYTE, b, one_in(20)));
    if (cfg_mask != '0 && !one_in(7)) begin
      do code = 4'($urandom_range(0, 14)); while (!cfg_mask[code]);
      b = {4'h0, code};
    end else begin
      b = one_in(2) ? 8'($urandom_range(0, 15)) : 8'($urandom);
    end
    send_event(mk_item(CMD_RX_BYTE, b, one_in(20)));
    guard = 0;
    while (rx_ph == RX_DATA && guard < 20) begin
      if (one_in(40)) send_event(mk_item(CMD_LINE_IDLE, 8'($urandom), 1'b0));
      else send_event(mk_item(CMD_RX_BYTE, 8'($urandom), one_in(40)));
      guard++;
    end
    guard = 0;
    while ((tx_ph == TX_CONF || tx_ph == TX_DATA) && guard < 40) begin
      r = $urandom_range(0, 29);
      case (r)
        0: send_event(mk_item(CMD_RX_BYTE, 8'($urandom), 1'($urandom)));
        1: send_event(mk_item(CMD_TX_DONE, 8'($urandom), 1'($urandom)));
        2: send_event(mk_item(CMD_LINE_IDLE, 8'($urandom), 1'($urandom)));
        default: send_event(mk_item(CMD_TX_READY, 8'($urandom), 1'($urandom)));
      endcase
      guard++;
    end
    if (tx_ph == TX_LAST) begin
      if (one_in(4)) send_event(mk_item(CMD_TX_READY, 8'($urandom), 1'($urandom)));
      if (!one_in(10)) send_event(mk_item(CMD_TX_DONE, 8'($urandom), 1'($urandom)));
    end
  endtask

  // Result side: stall in bursts, or run free for a while
  initial begin : result_side
    int n;
    out_stall = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if (!quiet && one_in(4)) begin
        out_stall <= 1'b1;
        n = $urandom_range(1, 19);
      end else begin
        out_stall <= 1'b0;
        n = $urandom_range(1, 40);
      end
      repeat (n) @(negedge clk);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    string diffs;
    if (rst_n && out_valid && !out_stall) begin
      if (due_results.size() == 0) begin
        log_failure("result with nothing outstanding", '0, out_item);
      end else begin
        want  = due_results.pop_front();
        diffs = field_diffs(want, out_item);
        if (diffs != "") log_failure({"wrong", diffs}, want, out_item);
      end
    end
  end

  initial begin : stimulus
    in_item_t  it;
    out_item_t typed_res;
    cfg_t      c;
    int        start_count;
    int        r;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    cfg_self   = '0;
    cfg_mask   = '0;
    cfg_rx_len = '0;
    cfg_tx_len = '0;
    rx_ph    = RX_ADDR;
    rx_cnt   = '0;
    cur_code = '0;
    tx_ph    = TX_IDLE;
    tx_left  = '0;
    tx_ofs   = '0;
    for (int i = 0; i < 256; i++) begin
      resp_mem[i]     = '0;
      resp_written[i] = 1'b0;
    end
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_ROWS[i].kind == ROW_SETUP) begin
        settle();
        load_config(DIR_CFG);
      end else begin
        it.cmd                  = DIR_ROWS[i].cmd;
        it.data_byte            = DIR_ROWS[i].data;
        it.parity_error         = DIR_ROWS[i].perr;
        it.resp_code            = DIR_ROWS[i].code;
        it.resp_index           = DIR_ROWS[i].idx;
        typed_res               = '0;
        typed_res.mute          = DIR_ROWS[i].mute;
        typed_res.tx_error      = DIR_ROWS[i].err;
        typed_res.tx_done       = DIR_ROWS[i].done;
        typed_res.frame_command = DIR_ROWS[i].fc;
        drive_item(it, DIR_ROWS[i].typed, typed_res);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      c.self_address        = 8'($urandom);
      c.command_enable_mask = 15'($urandom) | 15'($urandom);
      c.rx_length_table     = random_lengths();
      c.tx_length_table     = random_lengths();
      case (p)
        1: begin
          // every command replies with the longest response
          c.self_address        = 8'h00;
          c.command_enable_mask = 15'h7FFF;
          c.rx_length_table     = '0;
          c.tx_length_table     = {60{1'b1}};
        end
        2: begin
          c.self_address        = 8'hFF;
          c.command_enable_mask = 15'h7FFF;
          c.rx_length_table     = {60{1'b1}};
          c.tx_length_table     = '0;
        end
        4: c.command_enable_mask = '0;
        default: ;
      endcase
      load_config(c);
      start_count = sent;
      while (sent - start_count < PHASE_EVENTS) begin
        if (p == NUM_PHASES - 1 && sent - start_count >= PHASE_EVENTS / 2) begin
          quiet    = 1'b1;
          gap_odds = 0;
        end
        r = $urandom_range(0, 19);
        if (r < 16) begin
          send_frame();
        end else if (r < 18) begin
          send_event(mk_item(3'($urandom), 8'($urandom), 1'($urandom)));
        end else begin
          send_event(mk_item(CMD_RESP_WR, 8'($urandom), 1'($urandom)));
        end
      end
    end

    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatch_count == 0 && due_results.size() == 0) begin
      $display("multidrop_uart_slave_framer: match");
    end else begin
      $display("multidrop_uart_slave_framer: mismatch");
    end
    $finish;
  end

endmodule
